>>> src/spq_pkg.sv
package spq_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned MaxResults  = 16;

  typedef enum logic [2:0] {
    KIND_INSERT  = 3'd0,
    KIND_EXTRACT = 3'd1,
    KIND_PEEK    = 3'd2,
    KIND_CHANGE  = 3'd3,
    KIND_RAISE   = 3'd4,
    KIND_LOWER   = 3'd5,
    KIND_RSVD6   = 3'd6,
    KIND_RSVD7   = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_RANGE     = 3'd3,
    ST_DIRECTION = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic signed [31:0] new_priority;
    logic [3:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] out_value;
    logic signed [31:0] out_priority;
    logic [3:0]         found_position;
    logic [4:0]         count;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic               remove;
    logic               insert;
    logic signed [31:0] ins_value;
    logic signed [31:0] ins_priority;
  } cell_cmd_t;

endpackage

>>> src/spq_stream_if.sv
interface spq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/spq_cell.sv
module spq_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  spq_pkg::cell_cmd_t         cmd,
  input  logic                       sel_remove,
  input  logic                       sel_place,
  input  logic                       sel_shift,
  input  logic                       left_valid,
  input  logic signed [31:0]         left_value,
  input  logic signed [31:0]         left_priority,
  input  logic                       right_valid,
  input  logic signed [31:0]         right_value,
  input  logic signed [31:0]         right_priority,
  output logic                       valid,
  output logic signed [31:0]         value,
  output logic signed [31:0]         priority_q
);
  import spq_pkg::*;

  logic               valid_next;
  logic signed [31:0] value_next;
  logic signed [31:0] priority_next;

  always_comb begin
    valid_next    = valid;
    value_next    = value;
    priority_next = priority_q;
    if (cmd.remove && sel_remove) begin
      valid_next    = right_valid;
      value_next    = right_value;
      priority_next = right_priority;
    end else if (cmd.insert && sel_place) begin
      valid_next    = 1'b1;
      value_next    = cmd.ins_value;
      priority_next = cmd.ins_priority;
    end else if (cmd.insert && sel_shift) begin
      valid_next    = left_valid;
      value_next    = left_value;
      priority_next = left_priority;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    value      <= value_next;
    priority_q <= priority_next;
  end
endmodule

>>> src/sorted_priority_queue.sv
// Channel | Dir | Payload            | Beat
// in      | in  | spq_pkg::in_item_t | one operation
// out     | out | spq_pkg::out_item_t| one result, last marks the final one
// Each operation passes through the cell row in two steps: a decide and remove step,
// then an insert step that shifts every cell behind the insertion point by one.
// A peek skips the insert step and emits one beat per reported entry, one per cycle unless stalled.
// Reset empties the row at once; stored data is not cleared.
// Output stalls hold the result register and the sequencer.
module sorted_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::DefCapacity
) (
  input logic clk,
  input logic rst,
  spq_stream_if.sink   in,
  spq_stream_if.source out
);
  import spq_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_REMOVE = 4'b0010,
    S_INSERT = 4'b0100,
    S_PEEK   = 4'b1000
  } state_t;

  state_t state;
  in_item_t op;
  logic [CW-1:0] occ;
  logic do_remove, do_insert;
  logic signed [31:0] ins_value, ins_priority;
  logic [IW-1:0] peek_idx;
  logic [4:0] peek_cnt;

  logic               cv [CAPACITY];
  logic signed [31:0] cval [CAPACITY];
  logic signed [31:0] cpri [CAPACITY];
  logic [CAPACITY-1:0] ge_vec, match_vec;

  cell_cmd_t cmd;
  logic out_free;
  logic emit;
  logic rm_now, ins_now, peek_start;
  logic [IW-1:0] rm_sel;
  logic signed [31:0] mv_value;
  out_item_t res_next;
  assign out_free = !out.valid || out.ready;
  assign in.ready = (state == S_IDLE) && out_free;
  assign emit = out_free && ((state == S_INSERT) || (state == S_PEEK));

  always_comb begin
    cmd.remove       = (state == S_REMOVE) && rm_now;
    cmd.insert       = (state == S_INSERT) && do_insert && out_free;
    cmd.ins_value    = ins_value;
    cmd.ins_priority = ins_priority;
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic lv, rv;
      logic signed [31:0] lval, lpri, rval, rpri;
      logic place, shift;
      if (g == 0) begin : g_first
        assign lv = 1'b0; assign lval = '0; assign lpri = '0;
        assign place = !ge_vec[0];
        assign shift = 1'b0;
      end else begin : g_mid
        assign lv = cv[g-1]; assign lval = cval[g-1]; assign lpri = cpri[g-1];
        assign place = ge_vec[g-1] && !ge_vec[g];
        assign shift = !ge_vec[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign rv = 1'b0; assign rval = '0; assign rpri = '0;
      end else begin : g_inner
        assign rv = cv[g+1]; assign rval = cval[g+1]; assign rpri = cpri[g+1];
      end
      assign ge_vec[g]    = cv[g] && (cpri[g] >= ins_priority);
      assign match_vec[g] = cv[g] && (cval[g] == op.value);
      spq_cell u_cell (
        .clk, .rst, .cmd,
        .sel_remove(IW'(g) >= rm_sel),
        .sel_place(place), .sel_shift(shift),
        .left_valid(lv), .left_value(lval), .left_priority(lpri),
        .right_valid(rv), .right_value(rval), .right_priority(rpri),
        .valid(cv[g]), .value(cval[g]), .priority_q(cpri[g])
      );
    end
  endgenerate

  // first match search, priority encoder over the row
  logic          found;
  logic [IW-1:0] found_idx;
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        found     = 1'b1;
        found_idx = IW'(i);
      end
    end
  end

  logic pos_ok;
  logic signed [31:0] pos_pri;
  logic signed [31:0] pos_val;
  always_comb begin
    pos_ok  = ({{(32-CW){1'b0}}, occ} > 32'(op.position));
    pos_pri = '0;
    pos_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (32'(i) == 32'(op.position)) begin
        pos_pri = cpri[i];
        pos_val = cval[i];
      end
    end
  end

  out_item_t res;
  logic [4:0] occ5;
  assign occ5 = 5'(occ);

  // decide the operation and, if needed, take the entry out of the row
  always_comb begin
    res_next = '{status: ST_OK, out_value: '0, out_priority: '0,
                 found_position: '0, count: occ5, last: 1'b1};
    rm_now     = 1'b0;
    ins_now    = 1'b0;
    peek_start = 1'b0;
    rm_sel     = '0;
    mv_value   = ins_value;
    case (kind_t'(op.kind))
      KIND_INSERT: begin
        if (occ >= CW'(CAPACITY)) res_next.status = ST_FULL;
        else ins_now = 1'b1;
      end
      KIND_EXTRACT: begin
        if (occ == '0) res_next.status = ST_EMPTY;
        else begin
          rm_now                = 1'b1;
          res_next.out_value    = cval[0];
          res_next.out_priority = cpri[0];
        end
      end
      KIND_PEEK: begin
        if (occ == '0) res_next.status = ST_EMPTY;
        else peek_start = 1'b1;
      end
      KIND_CHANGE: begin
        if (!found) res_next.status = ST_NOT_FOUND;
        else begin
          res_next.found_position = 4'(found_idx);
          if (cpri[found_idx] != op.new_priority) begin
            rm_now   = 1'b1;
            ins_now  = 1'b1;
            rm_sel   = found_idx;
            mv_value = cval[found_idx];
          end
        end
      end
      KIND_RAISE, KIND_LOWER: begin
        if (!pos_ok) res_next.status = ST_RANGE;
        else if ((op.kind == KIND_RAISE) ? (op.new_priority <= pos_pri)
                                         : (op.new_priority >= pos_pri))
          res_next.status = ST_DIRECTION;
        else begin
          rm_now   = 1'b1;
          ins_now  = 1'b1;
          rm_sel   = IW'(op.position);
          mv_value = pos_val;
        end
      end
      default: ;
    endcase
    res_next.count = 5'(occ - CW'(rm_now) + CW'(ins_now));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      out.valid <= 1'b0;
      do_remove <= 1'b0;
      do_insert <= 1'b0;
    end else begin
      if (emit) out.valid <= 1'b1;
      else if (out.ready) out.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in.valid && in.ready) begin
            op           <= in.data;
            ins_value    <= in.data.value;
            ins_priority <= in.data.new_priority;
            do_remove    <= 1'b0;
            do_insert    <= 1'b0;
            state        <= S_REMOVE;
          end
        end
        S_REMOVE: begin
          res       <= res_next;
          do_remove <= rm_now;
          do_insert <= ins_now;
          ins_value <= mv_value;
          peek_idx  <= '0;
          peek_cnt  <= '0;
          state     <= peek_start ? S_PEEK : S_INSERT;
        end
        S_INSERT: begin
          if (out_free) begin
            occ       <= occ - CW'(do_remove) + CW'(do_insert);
            state     <= S_IDLE;
            do_insert <= 1'b0;
            do_remove <= 1'b0;
            out.data  <= res;
          end
        end
        S_PEEK: begin
          if (out_free) begin
            out.data.status         <= ST_OK;
            out.data.out_value      <= cval[peek_idx];
            out.data.out_priority   <= cpri[0];
            out.data.found_position <= '0;
            out.data.count          <= occ5;
            if (32'(peek_idx) + 1 >= 32'(occ) || peek_cnt == 5'(MaxResults - 1) ||
                cpri[32'(peek_idx) + 1 < CAPACITY ? peek_idx + IW'(1) : peek_idx]
                  != cpri[0]) begin
              out.data.last <= 1'b1;
              state         <= S_IDLE;
            end else begin
              out.data.last <= 1'b0;
              peek_idx      <= peek_idx + IW'(1);
              peek_cnt      <= peek_cnt + 5'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) occ <= CW'(CAPACITY))
    else $error("occupancy beyond capacity");
  assert property (@(posedge clk) disable iff (rst) in.ready |-> state == S_IDLE)
    else $error("ready outside idle");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && occ != '0) |-> cv[0])
    else $error("head cell empty with nonzero occupancy");
endmodule
